@@ src/i2r_pkg.sv @@
// shared types, constants and lookup functions for the roman numeral converter
package i2r_pkg;

	localparam int unsigned ValueW = 12;
	localparam int unsigned LetterW = 8;
	localparam int unsigned DigitW = 4;
	localparam int unsigned NumPlaces = 4;
	localparam logic [ValueW-1:0] MaxValue = 12'd3999;

	localparam logic [LetterW-1:0] LetterI = 8'h49;
	localparam logic [LetterW-1:0] LetterV = 8'h56;
	localparam logic [LetterW-1:0] LetterX = 8'h58;
	localparam logic [LetterW-1:0] LetterL = 8'h4c;
	localparam logic [LetterW-1:0] LetterC = 8'h43;
	localparam logic [LetterW-1:0] LetterD = 8'h44;
	localparam logic [LetterW-1:0] LetterM = 8'h4d;
	localparam logic [LetterW-1:0] LetterNone = 8'h00;

	// place order: thousands, hundreds, tens, units
	localparam logic [1:0] PlaceTh = 2'd0;
	localparam logic [1:0] PlaceHu = 2'd1;
	localparam logic [1:0] PlaceTe = 2'd2;
	localparam logic [1:0] PlaceUn = 2'd3;

	typedef enum logic [1:0] {
		CODE_UNIT = 2'd0,
		CODE_FIVE = 2'd1,
		CODE_TEN  = 2'd2
	} code_t;

	typedef logic [NumPlaces-1:0][DigitW-1:0] dig_row_t;

	typedef struct packed {
		logic              err;
		logic [1:0]        th;
		logic [DigitW-1:0] hu;
		logic [DigitW-1:0] te;
		logic [DigitW-1:0] un;
	} dig_word_t;

	function automatic logic [2:0] dig_len(input logic [DigitW-1:0] d);
		logic [2:0] len;
		case (d)
			4'd1: len = 3'd1;
			4'd2: len = 3'd2;
			4'd3: len = 3'd3;
			4'd4: len = 3'd2;
			4'd5: len = 3'd1;
			4'd6: len = 3'd2;
			4'd7: len = 3'd3;
			4'd8: len = 3'd4;
			4'd9: len = 3'd2;
			default: len = 3'd0;
		endcase
		return len;
	endfunction

	function automatic code_t dig_code(input logic [DigitW-1:0] d, input logic [1:0] k);
		code_t code;
		case (d)
			4'd4: code = (k == 2'd1) ? CODE_FIVE : CODE_UNIT;
			4'd5, 4'd6, 4'd7, 4'd8: code = (k == 2'd0) ? CODE_FIVE : CODE_UNIT;
			4'd9: code = (k == 2'd1) ? CODE_TEN : CODE_UNIT;
			default: code = CODE_UNIT;
		endcase
		return code;
	endfunction

	function automatic logic [LetterW-1:0] place_letter(input logic [1:0] p, input code_t code);
		logic [LetterW-1:0] unit_l;
		logic [LetterW-1:0] five_l;
		logic [LetterW-1:0] ten_l;
		logic [LetterW-1:0] res;
		case (p)
			PlaceTh: begin
				unit_l = LetterM;
				five_l = LetterM;
				ten_l  = LetterM;
			end
			PlaceHu: begin
				unit_l = LetterC;
				five_l = LetterD;
				ten_l  = LetterM;
			end
			PlaceTe: begin
				unit_l = LetterX;
				five_l = LetterL;
				ten_l  = LetterC;
			end
			default: begin
				unit_l = LetterI;
				five_l = LetterV;
				ten_l  = LetterX;
			end
		endcase
		case (code)
			CODE_FIVE: res = five_l;
			CODE_TEN:  res = ten_l;
			default:   res = unit_l;
		endcase
		return res;
	endfunction

	// first place at or after from that holds a nonzero digit, bit 2 set when none
	function automatic logic [2:0] first_nz(input dig_row_t d, input logic [2:0] from);
		logic [2:0] idx;
		logic       found;
		idx = 3'd4;
		found = 1'b0;
		for (int i = 0; i < NumPlaces; i++) begin
			if (!found && (3'(i) >= from) && (d[i] != '0)) begin
				idx = 3'(i);
				found = 1'b1;
			end
		end
		return idx;
	endfunction

endpackage

@@ src/i2r_split.sv @@
// three stage decimal digit split whose first stage is the input register
module i2r_split (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [i2r_pkg::ValueW-1:0]   value,
	output logic                         busy,
	output logic                         out_vld,
	output i2r_pkg::dig_word_t           out_word,
	input  logic                         out_rdy
);
	import i2r_pkg::*;

	logic                vld_s1, vld_s2, vld_s3;
	logic                rdy_s1, rdy_s2, rdy_s3;
	logic [ValueW-1:0]   value_s1;
	logic                err_s2, err_s3;
	logic [1:0]          th_s2, th_s3;
	logic [9:0]          r1_s2;
	logic [DigitW-1:0]   hu_s3;
	logic [6:0]          r2_s3;

	logic                err_c;
	logic [1:0]          th_c;
	logic [ValueW-1:0]   thm_c;
	logic [ValueW-1:0]   r1_c;
	logic [15:0]         hprod_c;
	logic [DigitW-1:0]   hu_c;
	logic [10:0]         hum_c;
	logic [10:0]         r2_c;
	logic [14:0]         tprod_c;
	logic [DigitW-1:0]   te_c;
	logic [6:0]          tem_c;
	logic [6:0]          un_c;

	assign rdy_s3 = !vld_s3 || out_rdy;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign busy   = !rdy_s1;

	// thousands by compare, remainder below one thousand for values up to 3999
	always_comb begin
		err_c = (value_s1 == '0) || (value_s1 > MaxValue);
		if (value_s1 >= 12'd3000) begin
			th_c  = 2'd3;
			thm_c = 12'd3000;
		end else if (value_s1 >= 12'd2000) begin
			th_c  = 2'd2;
			thm_c = 12'd2000;
		end else if (value_s1 >= 12'd1000) begin
			th_c  = 2'd1;
			thm_c = 12'd1000;
		end else begin
			th_c  = 2'd0;
			thm_c = 12'd0;
		end
		r1_c = value_s1 - thm_c;
	end

	// hundreds by reciprocal multiply, 41/4096 is exact below one thousand
	always_comb begin
		hprod_c = 16'(r1_s2) * 16'd41;
		hu_c    = hprod_c[15:12];
		hum_c   = 11'(hu_c) * 11'd100;
		r2_c    = 11'(r1_s2) - hum_c;
	end

	// tens by reciprocal multiply, 205/2048 is exact below one hundred
	always_comb begin
		tprod_c = 15'(r2_s3) * 15'd205;
		te_c    = tprod_c[14:11];
		tem_c   = 7'(te_c) * 7'd10;
		un_c    = r2_s3 - tem_c;
	end

	assign out_vld      = vld_s3;
	assign out_word.err = err_s3;
	assign out_word.th  = th_s3;
	assign out_word.hu  = hu_s3;
	assign out_word.te  = te_c;
	assign out_word.un  = un_c[DigitW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= start;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			value_s1 <= value;
		end
		if (rdy_s2) begin
			err_s2 <= err_c;
			th_s2  <= th_c;
			r1_s2  <= r1_c[9:0];
		end
		if (rdy_s3) begin
			err_s3 <= err_s2;
			th_s3  <= th_s2;
			hu_s3  <= hu_c;
			r2_s3  <= r2_c[6:0];
		end
	end

	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && !rdy_s3 |=> vld_s3 && $stable(r2_s3) && $stable(hu_s3))
		else $error("stage 3 word changed while stalled");

endmodule

@@ src/i2r_emit.sv @@
// letter sequencer over the four digits and the result register
module i2r_emit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_vld,
	input  i2r_pkg::dig_word_t           in_word,
	output logic                         in_rdy,
	output logic                         strobe,
	output logic [i2r_pkg::LetterW-1:0]  letter,
	output logic                         last,
	output logic                         error
);
	import i2r_pkg::*;

	logic                em_vld_q;
	logic                em_err_q;
	dig_row_t            dig_q;
	logic [1:0]          p_q;
	logic [1:0]          k_q;
	logic                strobe_q;
	logic [LetterW-1:0]  letter_q;
	logic                last_q;
	logic                error_q;

	dig_row_t            in_row;
	logic [2:0]          first_c;
	logic [DigitW-1:0]   cur_d;
	logic                fin_dig;
	logic [2:0]          nxt_c;
	logic                last_now;
	logic                em_free;
	logic                load;
	logic [LetterW-1:0]  cur_letter;

	always_comb begin
		in_row[PlaceTh] = {2'b00, in_word.th};
		in_row[PlaceHu] = in_word.hu;
		in_row[PlaceTe] = in_word.te;
		in_row[PlaceUn] = in_word.un;
		first_c    = first_nz(in_row, 3'd0);
		cur_d      = dig_q[p_q];
		fin_dig    = ({1'b0, k_q} == (dig_len(cur_d) - 3'd1));
		nxt_c      = first_nz(dig_q, {1'b0, p_q} + 3'd1);
		last_now   = em_err_q || (fin_dig && nxt_c[2]);
		em_free    = !em_vld_q || last_now;
		load       = in_vld && em_free;
		cur_letter = em_err_q ? LetterNone : place_letter(p_q, dig_code(cur_d, k_q));
	end

	assign in_rdy = em_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_vld_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= em_vld_q;
			if (load) begin
				em_vld_q <= 1'b1;
			end else if (last_now) begin
				em_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			em_err_q <= in_word.err;
			dig_q    <= in_row;
			p_q      <= first_c[1:0];
			k_q      <= 2'd0;
		end else if (em_vld_q) begin
			if (fin_dig) begin
				p_q <= nxt_c[1:0];
				k_q <= 2'd0;
			end else begin
				k_q <= k_q + 2'd1;
			end
		end
		letter_q <= cur_letter;
		last_q   <= last_now;
		error_q  <= em_err_q;
	end

	assign strobe = strobe_q;
	assign letter = letter_q;
	assign last   = last_q;
	assign error  = error_q;

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> em_vld_q)
		else $error("loaded word not held by sequencer");

	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		em_vld_q && !em_err_q |-> ({1'b0, k_q} < dig_len(cur_d)))
		else $error("letter index past digit pattern");

	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		em_vld_q && em_err_q |=> strobe_q && last_q && error_q && (letter_q == LetterNone))
		else $error("error word not a single marked result");

endmodule

@@ src/integer_to_roman_numeral.sv @@
// integer to roman numeral converter, top level
//
//   channel   ports                          handshake
//   input     value[11:0]                    start high and busy low at clk edge
//   result    letter[7:0], last, error       strobe high for one cycle, no stall
//
// one letter per cycle: an item yields one letter per letter of its numeral (1 to 15),
// an error word a single marked letter; the letter sequencer steps through them
// a word passes the digit split pipeline and the sequencer word register before its first letter is registered
// the next word is taken while the current numeral drains; busy rises only when the
// digit split pipeline is full behind the sequencer
// arst_n clears all valid flags; nothing else needs reset
module integer_to_roman_numeral (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [i2r_pkg::ValueW-1:0]   value,
	output logic                         strobe,
	output logic [i2r_pkg::LetterW-1:0]  letter,
	output logic                         last,
	output logic                         error
);
	import i2r_pkg::*;

	logic       word_vld;
	logic       word_rdy;
	dig_word_t  word;

	i2r_split u_split (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.value    (value),
		.busy     (busy),
		.out_vld  (word_vld),
		.out_word (word),
		.out_rdy  (word_rdy)
	);

	i2r_emit u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (word_vld),
		.in_word (word),
		.in_rdy  (word_rdy),
		.strobe  (strobe),
		.letter  (letter),
		.last    (last),
		.error   (error)
	);

endmodule

@@ test/integer_to_roman_numeral_tb.sv @@
// testbench for integer_to_roman_numeral: random and directed values checked letter by letter
module integer_to_roman_numeral_tb;
	import i2r_pkg::*;

	localparam int unsigned CycleLimit = 60000;
	localparam int unsigned TailCycles = 20;
	localparam int unsigned RandomItems = 125;

	typedef struct packed {
		logic [LetterW-1:0] letter;
		logic               last;
		logic               error;
	} glyph_word_t;

	typedef struct packed {
		logic [ValueW-1:0] num;
		logic              drain;
	} number_item_t;

	// letters by place (thousands..units) and by unit, five, ten code
	localparam logic [NumPlaces-1:0][2:0][LetterW-1:0] Glyphs = {
		{LetterX, LetterV, LetterI},
		{LetterC, LetterL, LetterX},
		{LetterM, LetterD, LetterC},
		{LetterM, LetterM, LetterM}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [ValueW-1:0]   value = '0;
	logic                busy;
	logic                strobe;
	logic [LetterW-1:0]  letter;
	logic                last;
	logic                error;

	number_item_t        number_q [$];
	glyph_word_t         numeral_q [$];
	int unsigned         words_sent = 0;
	int unsigned         total_words = 0;
	int unsigned         mismatches = 0;
	int unsigned         cycles = 0;

	integer_to_roman_numeral uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.value  (value),
		.strobe (strobe),
		.letter (letter),
		.last   (last),
		.error  (error)
	);

	always #4 clk = ~clk;

	task automatic queue_numeral(input logic [ValueW-1:0] num);
		int unsigned        dig [NumPlaces];
		logic [LetterW-1:0] seq [$];
		if (num == '0 || num > MaxValue) begin
			numeral_q.push_back('{LetterNone, 1'b1, 1'b1});
		end else begin
			dig[0] = num / 1000;
			dig[1] = (num / 100) % 10;
			dig[2] = (num / 10) % 10;
			dig[3] = num % 10;
			for (int p = 0; p < NumPlaces; p++) begin
				case (dig[p])
					4: begin
						seq.push_back(Glyphs[p][CODE_UNIT]);
						seq.push_back(Glyphs[p][CODE_FIVE]);
					end
					9: begin
						seq.push_back(Glyphs[p][CODE_UNIT]);
						seq.push_back(Glyphs[p][CODE_TEN]);
					end
					default: begin
						if (dig[p] >= 5)
							seq.push_back(Glyphs[p][CODE_FIVE]);
						for (int k = 0; k < dig[p] % 5; k++)
							seq.push_back(Glyphs[p][CODE_UNIT]);
					end
				endcase
			end
			foreach (seq[i])
				numeral_q.push_back('{seq[i], 1'(i == seq.size() - 1), 1'b0});
		end
	endtask

	function automatic logic [ValueW-1:0] random_number();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 5)
			return '0;
		else if (pick < 13)
			return ValueW'($urandom_range(4095, 4000));
		else if (pick < 30)
			return ValueW'($urandom_range(3, 0) * 1000 + $urandom_range(9, 5) * 100
				+ $urandom_range(9, 5) * 10 + $urandom_range(9, 5));
		else
			return ValueW'($urandom_range(3999, 1));
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			value <= '0;
		end else begin : drive
			int unsigned idle_pct;
			if (start && !busy) begin
				queue_numeral(value);
				words_sent++;
			end
			if (words_sent < total_words / 3)
				idle_pct = 6;
			else if (words_sent < 2 * total_words / 3)
				idle_pct = 46;
			else
				idle_pct = 0;
			if (start && busy) begin
				// hold the word until it is taken
			end else if (number_q.size() != 0
					&& !(number_q[0].drain && numeral_q.size() != 0)
					&& $urandom_range(99) >= idle_pct) begin
				start <= 1'b1;
				value <= number_q[0].num;
				void'(number_q.pop_front());
			end else begin
				start <= 1'b0;
				value <= ValueW'($urandom);
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && strobe) begin : check
			glyph_word_t want;
			if (numeral_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: letter %h last %b error %b",
						letter, last, error);
			end else begin
				want = numeral_q.pop_front();
				if (letter !== want.letter || last !== want.last || error !== want.error) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: letter %h/%h last %b/%b error %b/%b (expected/actual)",
							want.letter, letter, want.last, last, want.error, error);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("integer_to_roman_numeral test failed");
			$finish;
		end
	end

	initial begin
		logic [ValueW-1:0] directed [$];
		directed = '{12'd0, 12'd1, 12'd3999, 12'd4000, 12'd4095, 12'd3888, 12'd4, 12'd9,
			12'd40, 12'd90, 12'd400, 12'd900, 12'd5, 12'd50, 12'd500, 12'd1000,
			12'd2000, 12'd3000, 12'd1994, 12'd444, 12'd999, 12'd2048, 12'd1365,
			12'd2730, 12'd3};
		foreach (directed[i])
			number_q.push_back('{directed[i], 1'b0});
		for (int i = 0; i < RandomItems; i++)
			number_q.push_back('{random_number(), 1'(i == 5 || i == 60 || i == 110)});
		total_words = number_q.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (number_q.size() != 0 || start || numeral_q.size() != 0)
			@(posedge clk);
		repeat (TailCycles) @(posedge clk);

		if (mismatches == 0 && numeral_q.size() == 0)
			$display("integer_to_roman_numeral test passed");
		else
			$display("integer_to_roman_numeral test failed");
		$finish;
	end

endmodule
